/* hdl/satu_pkg.sv */
package satu_pkg;

    // Table geometry.
    localparam int ENTRY_SLOTS = 1024;
    localparam int SLOT_W      = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
    localparam int ENTRY_ID_W  = 10;
    localparam int COUNT_W     = 8;

    // Reciprocal used to fold an entry id into the table range.
    localparam int MOD_SH      = 2 * ENTRY_ID_W;
    localparam int RECIP_W     = MOD_SH;
    localparam logic [RECIP_W-1:0] MOD_RECIP = RECIP_W'((2 ** MOD_SH) / ENTRY_SLOTS);

    // Stream and configuration port widths.
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REQ_CONF   = 2'd0,
        CFG_MISS_LIMIT = 2'd1,
        CFG_UPD_DEACT  = 2'd2
    } cfg_index_t;

    // Decision codes of a result.
    typedef enum logic [1:0] {
        DEC_SKIP   = 2'd0,
        DEC_KEEP   = 2'd1,
        DEC_REMOVE = 2'd2,
        DEC_DEACT  = 2'd3
    } decision_t;

    // One table entry as stored in the memory.
    typedef struct packed {
        logic               seen;
        logic               running;
        logic [COUNT_W-1:0] confirm;
        logic [COUNT_W-1:0] miss;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Fold an entry id into the table: reciprocal estimate plus one correction.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [ENTRY_ID_W-1:0] id);
        logic [ENTRY_ID_W+RECIP_W-1:0] prod;
        logic [ENTRY_ID_W-1:0]         quot;
        logic [ENTRY_ID_W-1:0]         rem;
        prod = {{RECIP_W{1'b0}}, id} * {{ENTRY_ID_W{1'b0}}, MOD_RECIP};
        quot = prod[ENTRY_ID_W+RECIP_W-1:MOD_SH];
        rem  = id - ENTRY_ID_W'(int'(quot) * ENTRY_SLOTS);
        if (ENTRY_SLOTS >= (2 ** ENTRY_ID_W)) begin
            rem = id;
        end else if (int'(rem) >= ENTRY_SLOTS) begin
            rem = rem - ENTRY_ID_W'(ENTRY_SLOTS);
        end
        return SLOT_W'(rem);
    endfunction

endpackage

/* hdl/satu_ram.sv */
module satu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/submap_activity_tracker_unit.sv */
// Each result passes the update stage, where its table entry is read, and then the
// output register. Throughput: one observation per cycle while the result stream does
// not stall; a repeated id follows back to back through forwarding of the entry written
// by the table read-modify-write. Reset: aresetn (synchronous, active low) clears the
// control registers and then runs a clearing pass over all ENTRY_SLOTS (1024) entries
// of the table, during which s_tready stays low.
module submap_activity_tracker_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Observation stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [satu_pkg::S_TDATA_W-1:0]      s_tdata,  // entry_id, is_active, was_tracked
    input  logic                                s_tuser,  // is_free_space
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // decision, deactivate_update, confirmations_left, misses_left
    output logic [satu_pkg::M_TDATA_W-1:0]      m_tdata,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [satu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [satu_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import satu_pkg::*;

    // Configuration registers.
    logic [COUNT_W-1:0] req_conf_reg;
    logic [COUNT_W-1:0] miss_limit_reg;
    logic               upd_deact_reg;

    // Clearing pass.
    logic              clr_done_reg;
    logic [SLOT_W-1:0] clr_cnt_reg;

    // Update stage: the observation whose table entry is being read.
    logic              b_vld_reg;
    logic [SLOT_W-1:0] b_slot_reg;
    logic              b_active_reg;
    logic              b_free_reg;
    logic              b_tracked_reg;
    logic              fwd_sel_reg;
    entry_t            fwd_data_reg;

    // Output register.
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic              in_xfer;
    logic [SLOT_W-1:0] in_slot;
    logic              b_adv;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            cur;
    entry_t            upd;
    decision_t         dec;
    logic              pass;
    logic [COUNT_W-1:0] miss_start;
    logic [COUNT_W-1:0] miss_after;
    logic [COUNT_W-1:0] conf_out;
    logic [COUNT_W-1:0] miss_out;
    logic              deact_upd;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign b_adv     = b_vld_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = clr_done_reg && (!b_vld_reg || b_adv);
    assign in_xfer   = s_tvalid && s_tready;
    assign in_slot   = slot_of(s_tdata[ENTRY_ID_W-1:0]);

    // Entry table: the clearing pass owns the write port until it is done.
    assign ram_we    = !clr_done_reg || b_adv;
    assign ram_waddr = clr_done_reg ? b_slot_reg : clr_cnt_reg;
    assign ram_wdata = clr_done_reg ? ENTRY_W'(upd) : '0;

    satu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRY_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (in_slot),
        .rdata (ram_rdata)
    );

    // Current entry, taken from the write in flight when the same slot was just updated.
    assign cur = fwd_sel_reg ? fwd_data_reg : entry_t'(ram_rdata);

    // Confirmation and miss checks.
    always_comb begin
        upd        = cur;
        dec        = DEC_KEEP;
        pass       = 1'b1;
        miss_start = cur.running ? cur.miss : miss_limit_reg;
        miss_after = (miss_start != '0) ? miss_start - 1'b1 : '0;
        if (!b_active_reg || b_free_reg) begin
            dec = DEC_SKIP;
        end else begin
            if (req_conf_reg != '0) begin
                if (!cur.seen) begin
                    upd.seen    = 1'b1;
                    upd.confirm = req_conf_reg;
                end else if (cur.confirm != '0) begin
                    if (b_tracked_reg) begin
                        upd.confirm = cur.confirm - 1'b1;
                    end else begin
                        pass = 1'b0;
                    end
                end
            end
            if (!pass) begin
                dec = DEC_REMOVE;
            end else if (miss_limit_reg != '0) begin
                if (b_tracked_reg) begin
                    upd.running = 1'b0;
                end else begin
                    upd.running = 1'b1;
                    upd.miss    = miss_after;
                    if (miss_after == '0) begin
                        dec = DEC_DEACT;
                    end
                end
            end
        end
        conf_out  = upd.seen ? upd.confirm : '0;
        miss_out  = upd.running ? upd.miss : '0;
        deact_upd = (dec == DEC_DEACT) ? upd_deact_reg : 1'b0;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_conf_reg   <= '0;
            miss_limit_reg <= '0;
            upd_deact_reg  <= 1'b0;
            clr_done_reg   <= 1'b0;
            clr_cnt_reg    <= '0;
            b_vld_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // Configuration write transfer.
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_REQ_CONF:   req_conf_reg   <= cfg_data;
                    CFG_MISS_LIMIT: miss_limit_reg <= cfg_data;
                    CFG_UPD_DEACT:  upd_deact_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            // Clearing pass over the table after reset.
            if (!clr_done_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SLOT_W'(ENTRY_SLOTS - 1)) begin
                    clr_done_reg <= 1'b1;
                end
            end
            // Update stage occupancy.
            if (in_xfer) begin
                b_vld_reg <= 1'b1;
            end else if (b_adv) begin
                b_vld_reg <= 1'b0;
            end
            // Result register occupancy.
            if (b_adv) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            b_slot_reg    <= in_slot;
            b_active_reg  <= s_tdata[ENTRY_ID_W];
            b_tracked_reg <= s_tdata[ENTRY_ID_W+1];
            b_free_reg    <= s_tuser;
            // Forward the entry being written when the next observation hits the same slot.
            fwd_sel_reg   <= b_adv && (b_slot_reg == in_slot);
            fwd_data_reg  <= upd;
        end
        if (b_adv) begin
            m_tdata_reg <= M_TDATA_W'({miss_out, conf_out, deact_upd, dec});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import satu_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 5;
    // The limit must cover the clearing pass after reset, during which no transfer happens.
    localparam int IDLE_LIMIT   = 5000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 130;
    localparam int DIR_COUNT    = 19;
    localparam int RESET_ROWS   = 3;
    localparam int HOLD_AT      = DIR_COUNT + 2 * PHASE_ITEMS + 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [ENTRY_ID_W-1:0] id;
        logic                  act;
        logic                  free;
        logic                  trk;
    } observation_t;

    typedef struct packed {
        decision_t          dec;
        logic               upd;
        logic [COUNT_W-1:0] conf;
        logic [COUNT_W-1:0] miss;
    } outcome_t;

    typedef struct packed {
        observation_t obs;
        logic         typed;
        outcome_t     outcome;
    } dir_row_t;

    // Directed observations. The first rows run with the reset settings, the rest with
    // two required confirmations, three misses to deactivate and the update flag set.
    localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
        '{'{10'd0,    1'b0, 1'b0, 1'b0}, 1'b1, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd1023, 1'b1, 1'b1, 1'b1}, 1'b1, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd512,  1'b1, 1'b0, 1'b0}, 1'b1, '{DEC_KEEP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd1023, 1'b1, 1'b0, 1'b1}, 1'b1, '{DEC_KEEP,   1'b0, 8'd2, 8'd0}},
        '{'{10'd1023, 1'b1, 1'b0, 1'b0}, 1'b1, '{DEC_REMOVE, 1'b0, 8'd2, 8'd0}},
        '{'{10'd1023, 1'b1, 1'b0, 1'b1}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd1023, 1'b1, 1'b0, 1'b1}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd1023, 1'b1, 1'b0, 1'b0}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd1023, 1'b1, 1'b0, 1'b0}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd1023, 1'b1, 1'b0, 1'b0}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd1023, 1'b1, 1'b0, 1'b0}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd1023, 1'b0, 1'b0, 1'b0}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd1023, 1'b1, 1'b1, 1'b0}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd1023, 1'b1, 1'b0, 1'b1}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd512,  1'b1, 1'b0, 1'b0}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd512,  1'b1, 1'b0, 1'b0}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'h2AA,  1'b1, 1'b0, 1'b1}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'h155,  1'b1, 1'b0, 1'b0}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}},
        '{'{10'd512,  1'b1, 1'b0, 1'b1}, 1'b0, '{DEC_SKIP,   1'b0, 8'd0, 8'd0}}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shadow copy of the tracker settings and entry table.
    logic [COUNT_W-1:0] req_confirmations = '0;
    logic [COUNT_W-1:0] miss_limit        = '0;
    logic               deact_update      = 1'b0;
    bit                 seen_tbl    [ENTRY_SLOTS];
    bit [COUNT_W-1:0]   confirm_tbl [ENTRY_SLOTS];
    bit                 running_tbl [ENTRY_SLOTS];
    bit [COUNT_W-1:0]   miss_tbl    [ENTRY_SLOTS];

    outcome_t pending_outcomes[$];
    int       obs_sent      = 0;
    int       outcomes_seen = 0;
    int       error_count   = 0;
    int       settings_used = 0;
    int       decision_hits [4];
    int       idle_cycles   = 0;

    // Receiver stall pattern state.
    int       rx_mode      = 0;
    int       rx_mode_left = 0;
    int       hold_left    = 0;
    bit       hold_done    = 1'b0;

    submap_activity_tracker_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    // Apply one observation to the shadow table and return the decision it leads to.
    function automatic outcome_t track_observation(observation_t o);
        outcome_t         r;
        logic [SLOT_W-1:0] s;
        logic             confirmed_ok;
        s = SLOT_W'(int'(o.id) % ENTRY_SLOTS);
        r.dec = DEC_KEEP;
        confirmed_ok = 1'b1;
        if (!o.act || o.free) begin
            r.dec = DEC_SKIP;
        end else begin
            if (req_confirmations != 0) begin
                if (!seen_tbl[s]) begin
                    seen_tbl[s] = 1'b1;
                    confirm_tbl[s] = req_confirmations;
                end else if (confirm_tbl[s] != 0) begin
                    if (o.trk) begin
                        confirm_tbl[s] = confirm_tbl[s] - 1'b1;
                    end else begin
                        confirmed_ok = 1'b0;
                    end
                end
            end
            if (!confirmed_ok) begin
                r.dec = DEC_REMOVE;
            end else if (miss_limit != 0) begin
                if (o.trk) begin
                    running_tbl[s] = 1'b0;
                end else begin
                    if (!running_tbl[s]) begin
                        running_tbl[s] = 1'b1;
                        miss_tbl[s] = miss_limit;
                    end
                    if (miss_tbl[s] != 0) begin
                        miss_tbl[s] = miss_tbl[s] - 1'b1;
                    end
                    if (miss_tbl[s] == 0) begin
                        r.dec = DEC_DEACT;
                    end
                end
            end
        end
        r.upd  = (r.dec == DEC_DEACT) ? deact_update : 1'b0;
        r.conf = seen_tbl[s] ? confirm_tbl[s] : '0;
        r.miss = running_tbl[s] ? miss_tbl[s] : '0;
        return r;
    endfunction

    // Offer one observation and keep tvalid high until the transfer happens.
    task automatic offer_observation(input observation_t o, input logic typed,
                                     input outcome_t typed_outcome);
        outcome_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, o.trk, o.act, o.id};
        s_tuser  <= o.free;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        r = track_observation(o);
        pending_outcomes.push_back(typed ? typed_outcome : r);
        obs_sent++;
    endtask

    // Stop sending and wait until every result is back and the pipeline has drained.
    task automatic drain_outcomes();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // One register transfer; cfg_valid stays high so writes can follow back to back.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            CFG_REQ_CONF:   req_confirmations = value;
            CFG_MISS_LIMIT: miss_limit = value;
            CFG_UPD_DEACT:  deact_update = value[0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [7:0] conf, input logic [7:0] misses,
                                 input logic upd, input logic poke_unused);
        drain_outcomes();
        write_register(CFG_REQ_CONF, conf);
        write_register(CFG_MISS_LIMIT, misses);
        // Upper data bits of the flag register are random and must be dropped.
        write_register(CFG_UPD_DEACT, {7'($urandom), upd});
        if (poke_unused) begin
            write_register(CFG_UNUSED, 8'hFF);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] random_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 8'd255;
        end else if (pick == 1) begin
            return 8'($urandom);
        end
        return 8'($urandom_range(0, 5));
    endfunction

    // Receiver: changing stall patterns, plus one long hold-off in the middle of a phase.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && obs_sent >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(5, 60);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 9) < 7);
                2:       m_tready <= ~m_tready;
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Result checker: every transfer is compared with the oldest expectation.
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.dec  = decision_t'(m_tdata[1:0]);
            got.upd  = m_tdata[2];
            got.conf = m_tdata[10:3];
            got.miss = m_tdata[18:11];
            outcomes_seen++;
            if (pending_outcomes.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("Unexpected result transfer: m_tdata=%h", m_tdata);
                end
            end else begin
                want = pending_outcomes.pop_front();
                decision_hits[want.dec]++;
                if (got.dec !== want.dec || got.upd !== want.upd ||
                    got.conf !== want.conf || got.miss !== want.miss) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("Mismatch on result %0d: expected dec=%0d upd=%0b conf=%0d miss=%0d",
                                 outcomes_seen, want.dec, want.upd, want.conf, want.miss);
                        $display("    got dec=%0d upd=%0b conf=%0d miss=%0d",
                                 got.dec, got.upd, got.conf, got.miss);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        observation_t             o;
        logic [ENTRY_ID_W-1:0]    id_pool [16];
        int                       pool_size;
        int                       track_pct;
        int                       burst_left;
        bit                       gaps_on;
        logic [7:0]               conf_set;
        logic [7:0]               miss_set;
        logic                     upd_set;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: reset settings first, then a short confirmation and miss scenario.
        for (int i = 0; i < DIR_COUNT; i++) begin
            if (i == RESET_ROWS) begin
                load_settings(8'd2, 8'd3, 1'b1, 1'b1);
            end
            offer_observation(DIR_ROWS[i].obs, DIR_ROWS[i].typed, DIR_ROWS[i].outcome);
        end

        // Random part: each phase uses new settings and a small pool of hot entries.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin conf_set = 8'd255; miss_set = 8'd255; upd_set = 1'b0; end
                1: begin conf_set = 8'd1;   miss_set = 8'd1;   upd_set = 1'b1; end
                2: begin conf_set = 8'd0;   miss_set = 8'd2;   upd_set = 1'b1; end
                3: begin conf_set = 8'd3;   miss_set = 8'd0;   upd_set = 1'b0; end
                4: begin conf_set = 8'd0;   miss_set = 8'd0;   upd_set = 1'b1; end
                default: begin
                    conf_set = random_count();
                    miss_set = random_count();
                    upd_set  = 1'($urandom);
                end
            endcase
            load_settings(conf_set, miss_set, upd_set, 1'b0);
            pool_size = $urandom_range(2, 16);
            for (int k = 0; k < 16; k++) begin
                id_pool[k] = ENTRY_ID_W'($urandom);
            end
            track_pct  = $urandom_range(20, 80);
            gaps_on    = (p % 3 != 0);
            burst_left = $urandom_range(1, 16);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    o.id = ENTRY_ID_W'($urandom);
                end else begin
                    o.id = id_pool[$urandom_range(0, pool_size - 1)];
                end
                o.act  = ($urandom_range(0, 99) >= 7);
                o.free = ($urandom_range(0, 99) < 7);
                o.trk  = ($urandom_range(0, 99) < track_pct);
                offer_observation(o, 1'b0, '0);
                if (gaps_on) begin
                    burst_left--;
                    if (burst_left == 0) begin
                        s_tvalid <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge aclk);
                        burst_left = $urandom_range(1, 16);
                    end
                end
            end
        end

        drain_outcomes();
        repeat (10) @(posedge aclk);

        $display("Sent %0d observations under %0d register settings, %0d results checked.",
                 obs_sent, settings_used + 1, outcomes_seen);
        $display("Decisions seen: skip %0d, keep %0d, remove %0d, deactivate %0d; errors %0d.",
                 decision_hits[DEC_SKIP], decision_hits[DEC_KEEP],
                 decision_hits[DEC_REMOVE], decision_hits[DEC_DEACT], error_count);
        if (error_count == 0 && pending_outcomes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/satu_pkg.sv
hdl/satu_ram.sv
hdl/submap_activity_tracker_unit.sv
tb/testbench.sv
